FILE: rtl/vnp_pkg.sv
// Shared types, constants and helper functions for the value noise palette pixel pipeline.
package vnp_pkg;

  localparam int VNP_WIDTH  = 64;
  localparam int VNP_HEIGHT = 16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_SCALE          = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_X_OFFSET       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_OFFSET       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SEED           = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_SELECT = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_POST_MODE      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_STRIPE_PHASE   = 3'd6;

  localparam logic [1:0] PALETTE_OCEAN   = 2'd0;
  localparam logic [1:0] PALETTE_PARTY   = 2'd1;
  localparam logic [1:0] PALETTE_RAINBOW = 2'd2;

  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_STRIPE = 2'd1;
  localparam logic [1:0] MODE_ZEBRA  = 2'd2;

  localparam logic [31:0] PRIME_X = 32'd374761393;
  localparam logic [31:0] PRIME_Y = 32'd668265263;
  localparam logic [31:0] HASH_M1 = 32'h7feb352d;
  localparam logic [31:0] HASH_M2 = 32'h846ca68b;

  localparam logic [7:0] GREY_HIGH = 8'd220;
  localparam logic [7:0] GREY_LOW  = 8'd10;

  typedef struct packed {
    logic [7:0]  scale;
    logic [15:0] x_offset;
    logic [15:0] y_offset;
    logic [31:0] seed;
    logic [1:0]  palette_select;
    logic [1:0]  post_mode;
    logic [7:0]  stripe_phase;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    scale:          8'd14,
    x_offset:       16'd0,
    y_offset:       16'd0,
    seed:           32'd0,
    palette_select: PALETTE_OCEAN,
    post_mode:      MODE_PLAIN,
    stripe_phase:   8'd0
  };

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct packed {
    logic [3:0][31:0] h;
    logic [7:0]       fu;
    logic [7:0]       fv;
  } hash_t;

  typedef logic [255:0][7:0] smooth_tab_t;

  function automatic smooth_tab_t smooth_table();
    smooth_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = 8'((i * i * (765 - 2 * i)) / 65025);
    end
    return tab;
  endfunction

  localparam smooth_tab_t SMOOTH_TAB = smooth_table();

  // a + (b - a) * t / 255, quotient truncated toward zero
  function automatic logic [7:0] blend8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] t);
    logic signed [8:0] d;
    logic [7:0]        mag;
    logic [15:0]       p;
    logic [23:0]       s;
    logic [7:0]        q0;
    logic [15:0]       m255;
    logic [15:0]       rem;
    logic [7:0]        q;
    d    = $signed({1'b0, b}) - $signed({1'b0, a});
    mag  = d[8] ? 8'(-d) : d[7:0];
    p    = 16'(mag) * 16'(t);
    s    = {8'd0, p} + {p, 8'd0};
    q0   = s[23:16];
    m255 = {q0, 8'd0} - {8'd0, q0};
    rem  = p - m255;
    q    = (rem >= 16'd255) ? q0 + 8'd1 : q0;
    return d[8] ? a - q : a + q;
  endfunction

  function automatic rgb_t mk(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    return '{blue: b, green: g, red: r};
  endfunction

  function automatic rgb_t pal_lookup(input logic [1:0] sel, input logic [3:0] idx);
    rgb_t e;
    unique case (sel)
      PALETTE_PARTY: begin
        unique case (idx)
          4'd0:  e = mk(8'd255, 8'd0,   8'd0);
          4'd1:  e = mk(8'd255, 8'd64,  8'd0);
          4'd2:  e = mk(8'd255, 8'd128, 8'd0);
          4'd3:  e = mk(8'd255, 8'd255, 8'd0);
          4'd4:  e = mk(8'd128, 8'd255, 8'd0);
          4'd5:  e = mk(8'd0,   8'd255, 8'd0);
          4'd6:  e = mk(8'd0,   8'd255, 8'd128);
          4'd7:  e = mk(8'd0,   8'd255, 8'd255);
          4'd8:  e = mk(8'd0,   8'd128, 8'd255);
          4'd9:  e = mk(8'd0,   8'd0,   8'd255);
          4'd10: e = mk(8'd128, 8'd0,   8'd255);
          4'd11: e = mk(8'd255, 8'd0,   8'd255);
          4'd12: e = mk(8'd255, 8'd0,   8'd128);
          4'd13: e = mk(8'd255, 8'd0,   8'd64);
          4'd14: e = mk(8'd255, 8'd255, 8'd255);
          4'd15: e = mk(8'd0,   8'd0,   8'd0);
        endcase
      end
      PALETTE_RAINBOW: begin
        unique case (idx)
          4'd0:  e = mk(8'd255, 8'd0,   8'd0);
          4'd1:  e = mk(8'd255, 8'd64,  8'd0);
          4'd2:  e = mk(8'd255, 8'd128, 8'd0);
          4'd3:  e = mk(8'd255, 8'd192, 8'd0);
          4'd4:  e = mk(8'd255, 8'd255, 8'd0);
          4'd5:  e = mk(8'd128, 8'd255, 8'd0);
          4'd6:  e = mk(8'd0,   8'd255, 8'd0);
          4'd7:  e = mk(8'd0,   8'd255, 8'd128);
          4'd8:  e = mk(8'd0,   8'd255, 8'd255);
          4'd9:  e = mk(8'd0,   8'd128, 8'd255);
          4'd10: e = mk(8'd0,   8'd0,   8'd255);
          4'd11: e = mk(8'd128, 8'd0,   8'd255);
          4'd12: e = mk(8'd255, 8'd0,   8'd255);
          4'd13: e = mk(8'd255, 8'd0,   8'd128);
          4'd14: e = mk(8'd255, 8'd0,   8'd64);
          4'd15: e = mk(8'd255, 8'd0,   8'd0);
        endcase
      end
      default: begin
        unique case (idx)
          4'd0:  e = mk(8'd0,   8'd0,   8'd16);
          4'd1:  e = mk(8'd0,   8'd0,   8'd32);
          4'd2:  e = mk(8'd0,   8'd0,   8'd64);
          4'd3:  e = mk(8'd0,   8'd16,  8'd96);
          4'd4:  e = mk(8'd0,   8'd32,  8'd128);
          4'd5:  e = mk(8'd0,   8'd64,  8'd160);
          4'd6:  e = mk(8'd0,   8'd96,  8'd192);
          4'd7:  e = mk(8'd0,   8'd128, 8'd224);
          4'd8:  e = mk(8'd0,   8'd160, 8'd255);
          4'd9:  e = mk(8'd0,   8'd192, 8'd224);
          4'd10: e = mk(8'd0,   8'd224, 8'd192);
          4'd11: e = mk(8'd0,   8'd255, 8'd160);
          4'd12: e = mk(8'd32,  8'd255, 8'd192);
          4'd13: e = mk(8'd64,  8'd255, 8'd224);
          4'd14: e = mk(8'd128, 8'd255, 8'd255);
          4'd15: e = mk(8'd255, 8'd255, 8'd255);
        endcase
      end
    endcase
    return e;
  endfunction

endpackage

FILE: rtl/value_noise_palette_pixel_top.sv
// Top level of the value noise palette pixel pipeline with its configuration registers.
// Takes one pixel coordinate per clock and returns its RGB color through a pipeline of register
// stages; with m_tready held high the throughput is one pixel every cycle.
// All eight stages (noise coordinate, lattice hash in three steps, corner blend, noise blend,
// palette fetch, color blend) share one advance enable, so a low m_tready with m_tvalid high
// freezes the whole pipe and s_tready follows it. Configuration registers are written through
// the cfg channel, which is always ready; write them only while the pipe holds no pixel.
module value_noise_palette_pixel_top import vnp_pkg::*; #(
  parameter int WIDTH  = VNP_WIDTH,
  parameter int HEIGHT = VNP_HEIGHT,
  localparam int X_BITS  = (WIDTH > 1) ? $clog2(WIDTH) : 1,
  localparam int Y_BITS  = (HEIGHT > 1) ? $clog2(HEIGHT) : 1,
  localparam int IN_W    = ((X_BITS + Y_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_W-1:0]        s_tdata,   // pixel_x, pixel_y, zero pad
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [23:0]            m_tdata,   // red, green, blue
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t              cfg;
  logic              adv;
  logic              hs_valid, nz_valid;
  logic [X_BITS-1:0] hs_px, nz_px;
  hash_t             hs_hash;
  logic [7:0]        nz_noise;
  rgb_t              out_rgb;

  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv;
  assign cfg_ready = 1'b1;
  assign m_tdata   = out_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCALE:          cfg.scale          <= cfg_data[7:0];
        REG_X_OFFSET:       cfg.x_offset       <= cfg_data[15:0];
        REG_Y_OFFSET:       cfg.y_offset       <= cfg_data[15:0];
        REG_SEED:           cfg.seed           <= cfg_data[31:0];
        REG_PALETTE_SELECT: cfg.palette_select <= cfg_data[1:0];
        REG_POST_MODE:      cfg.post_mode      <= cfg_data[1:0];
        REG_STRIPE_PHASE:   cfg.stripe_phase   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  vnp_hash #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_hash (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_px     (s_tdata[X_BITS-1:0]),
    .in_py     (s_tdata[X_BITS+Y_BITS-1:X_BITS]),
    .out_valid (hs_valid),
    .out_px    (hs_px),
    .out_hash  (hs_hash)
  );

  vnp_blend #(.WIDTH(WIDTH)) u_blend (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (hs_valid),
    .in_px     (hs_px),
    .in_hash   (hs_hash),
    .out_valid (nz_valid),
    .out_px    (nz_px),
    .out_noise (nz_noise)
  );

  vnp_color #(.WIDTH(WIDTH)) u_color (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .cfg       (cfg),
    .in_valid  (nz_valid),
    .in_px     (nz_px),
    .in_noise  (nz_noise),
    .out_valid (m_tvalid),
    .out_rgb   (out_rgb)
  );

  property p_ready_when_empty;
    @(posedge clk) disable iff (rst) !m_tvalid |-> s_tready;
  endproperty
  a_ready_when_empty: assert property (p_ready_when_empty)
    else $error("input stalled with an empty output stage");

  property p_empty_after_reset;
    @(posedge clk) $past(rst) |-> !m_tvalid && !hs_valid && !nz_valid;
  endproperty
  a_empty_after_reset: assert property (p_empty_after_reset)
    else $error("pipeline holds a pixel right after reset");

  property p_stall_freezes;
    @(posedge clk) disable iff (rst)
      !adv |=> $stable(hs_valid) && $stable(nz_valid) && $stable(m_tvalid);
  endproperty
  a_stall_freezes: assert property (p_stall_freezes)
    else $error("pipeline stage moved during a stall");

endmodule

FILE: rtl/vnp_hash.sv
// Noise coordinate, smoothstep fade and four-corner lattice hash, four register stages.
module vnp_hash import vnp_pkg::*; #(
  parameter int WIDTH  = VNP_WIDTH,
  parameter int HEIGHT = VNP_HEIGHT,
  localparam int X_BITS = (WIDTH > 1) ? $clog2(WIDTH) : 1,
  localparam int Y_BITS = (HEIGHT > 1) ? $clog2(HEIGHT) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  cfg_t              cfg,
  input  logic              in_valid,
  input  logic [X_BITS-1:0] in_px,
  input  logic [Y_BITS-1:0] in_py,
  output logic              out_valid,
  output logic [X_BITS-1:0] out_px,
  output hash_t             out_hash
);

  logic              vld0, vld1, vld2;
  logic [X_BITS-1:0] px0, px1, px2;
  logic [15:0]       nx, ny;
  logic [X_BITS+7:0] prod_x;
  logic [Y_BITS+7:0] prod_y;
  logic [15:0]       nx_next, ny_next;

  logic [8:0]        ex0, ex1, ey0, ey1;
  logic [31:0]       mx0, mx1, my0, my1;
  logic [3:0][31:0]  hk;
  logic [3:0][31:0]  h1, h1_next;
  logic [7:0]        fu1, fv1;

  logic [3:0][31:0]  h2, h2_next;
  logic [7:0]        fu2, fv2;
  logic [3:0][31:0]  h3_next;

  always_comb begin
    prod_x  = (X_BITS+8)'(in_px) * (X_BITS+8)'(cfg.scale);
    prod_y  = (Y_BITS+8)'(in_py) * (Y_BITS+8)'(cfg.scale);
    nx_next = 16'(prod_x) + cfg.x_offset;
    ny_next = 16'(prod_y) + cfg.y_offset;
  end

  always_comb begin
    ex0 = {1'b0, nx[15:8]};
    ex1 = ex0 + 9'd1;
    ey0 = {1'b0, ny[15:8]};
    ey1 = ey0 + 9'd1;
    mx0 = {23'd0, ex0} * PRIME_X;
    mx1 = {23'd0, ex1} * PRIME_X;
    my0 = {23'd0, ey0} * PRIME_Y;
    my1 = {23'd0, ey1} * PRIME_Y;
    hk[0] = cfg.seed ^ mx0 ^ my0;
    hk[1] = cfg.seed ^ mx1 ^ my0;
    hk[2] = cfg.seed ^ mx0 ^ my1;
    hk[3] = cfg.seed ^ mx1 ^ my1;
    for (int k = 0; k < 4; k++) begin
      h1_next[k] = hk[k] ^ (hk[k] >> 16);
      h2_next[k] = h1[k] * HASH_M1;
      h3_next[k] = (h2[k] ^ (h2[k] >> 15)) * HASH_M2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0      <= 1'b0;
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld0      <= in_valid;
      vld1      <= vld0;
      vld2      <= vld1;
      out_valid <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px0         <= in_px;
      nx          <= nx_next;
      ny          <= ny_next;
      px1         <= px0;
      h1          <= h1_next;
      fu1         <= SMOOTH_TAB[nx[7:0]];
      fv1         <= SMOOTH_TAB[ny[7:0]];
      px2         <= px1;
      h2          <= h2_next;
      fu2         <= fu1;
      fv2         <= fv1;
      out_px      <= px2;
      out_hash.h  <= h3_next;
      out_hash.fu <= fu2;
      out_hash.fv <= fv2;
    end
  end

endmodule

FILE: rtl/vnp_blend.sv
// Bilinear blend of the four corner bytes into one noise byte, two register stages.
module vnp_blend import vnp_pkg::*; #(
  parameter int WIDTH = VNP_WIDTH,
  localparam int X_BITS = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [X_BITS-1:0] in_px,
  input  hash_t             in_hash,
  output logic              out_valid,
  output logic [X_BITS-1:0] out_px,
  output logic [7:0]        out_noise
);

  logic              vld4;
  logic [X_BITS-1:0] px4;
  logic [7:0]        top, bot, fv4;
  logic [3:0][7:0]   c;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      c[k] = in_hash.h[k][31:24];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld4      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld4      <= in_valid;
      out_valid <= vld4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px4       <= in_px;
      top       <= blend8(c[0], c[1], in_hash.fu);
      bot       <= blend8(c[2], c[3], in_hash.fu);
      fv4       <= in_hash.fv;
      out_px    <= px4;
      out_noise <= blend8(top, bot, fv4);
    end
  end

endmodule

FILE: rtl/vnp_color.sv
// Post mode, palette lookup and color interpolation (or a flat grey in zebra mode), two register stages.
module vnp_color import vnp_pkg::*; #(
  parameter int WIDTH = VNP_WIDTH,
  localparam int X_BITS = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  cfg_t              cfg,
  input  logic              in_valid,
  input  logic [X_BITS-1:0] in_px,
  input  logic [7:0]        in_noise,
  output logic              out_valid,
  output rgb_t              out_rgb
);

  logic       vld6;
  logic       grey, grey_hi, grey_q;
  logic [7:0] idx, zg, w;
  logic [7:0] px32, px24;
  rgb_t       ea, eb;

  always_comb begin
    px32    = 8'({16'(in_px), 5'd0});
    px24    = 8'({16'(in_px), 4'd0}) + 8'({16'(in_px), 3'd0});
    zg      = in_noise + px24;
    idx     = (cfg.post_mode == MODE_STRIPE) ? in_noise + px32 + cfg.stripe_phase : in_noise;
    grey    = (cfg.post_mode == MODE_ZEBRA);
    grey_hi = zg[7];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld6      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld6      <= in_valid;
      out_valid <= vld6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ea      <= pal_lookup(cfg.palette_select, idx[7:4]);
      eb      <= pal_lookup(cfg.palette_select, idx[7:4] + 4'd1);
      w       <= grey ? (grey_hi ? GREY_HIGH : GREY_LOW) : {idx[3:0], idx[3:0]};
      grey_q  <= grey;
      if (grey_q) begin
        out_rgb <= '{blue: w, green: w, red: w};
      end else begin
        out_rgb.red   <= blend8(ea.red,   eb.red,   w);
        out_rgb.green <= blend8(ea.green, eb.green, w);
        out_rgb.blue  <= blend8(ea.blue,  eb.blue,  w);
      end
    end
  end

  property p_grey_out;
    @(posedge clk) disable iff (rst)
      $past(adv) && $past(vld6) && $past(grey_q) |->
        out_valid && out_rgb.red == out_rgb.green && out_rgb.green == out_rgb.blue &&
        (out_rgb.red == GREY_HIGH || out_rgb.red == GREY_LOW);
  endproperty
  a_grey_out: assert property (p_grey_out) else $error("zebra pixel is not a valid grey");

endmodule
